>>> hw/rtl/iyfr_pkg.sv
// ----------------------------------------------------------------------------
// iyfr_pkg
// Types, codes and constants shared by the yaw frame receiver modules.
// ----------------------------------------------------------------------------
package iyfr_pkg;

	localparam int FRAME_BYTES_DEF = 11;

	localparam logic [7:0] HDR_BYTE = 8'h55;
	localparam logic [7:0] YAW_TYPE = 8'h53;
	localparam logic signed [8:0] YAW_SCALE = 9'sd180;

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_BYTE = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_RXERR = 2'd2;

	localparam logic REG_READ_TO = 1'b0;
	localparam logic REG_BODY_TO = 1'b1;

	localparam logic [15:0] READ_TO_RST = 16'd100;
	localparam logic [7:0] BODY_TO_RST = 8'd20;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
		logic rx_error;
	} item_t;

	typedef struct packed {
		logic valid;
		logic [1:0] status;
		logic signed [23:0] yaw_q15;
	} result_t;

endpackage

>>> hw/rtl/iyfr_parser.sv
// ----------------------------------------------------------------------------
// iyfr_parser
// Frame hunt, body collection, checksum, deadlines and yaw scaling for one
// item per enabled cycle.
// ----------------------------------------------------------------------------
module iyfr_parser
	import iyfr_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  item_t item,
	input  logic [15:0] read_to,
	input  logic [7:0] body_to,
	output result_t res
);

	localparam int PosW = $clog2(FRAME_BYTES);
	localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES - 1);
	localparam logic [PosW-1:0] TypePos = PosW'(1);
	localparam logic [PosW-1:0] YawLoPos = PosW'(6);
	localparam logic [PosW-1:0] YawHiPos = PosW'(7);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HUNT,
		PH_BODY
	} phase_t;

	phase_t phase_q, phase_d;
	logic [PosW-1:0] pos_q, pos_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] type_q, type_d;
	logic [7:0] ylo_q, ylo_d;
	logic [7:0] yhi_q, yhi_d;
	logic [15:0] read_q, read_d;
	logic [7:0] body_q, body_d;

	logic [15:0] read_inc;
	logic [7:0] body_inc;
	logic signed [15:0] raw;
	logic signed [23:0] yaw;

	assign read_inc = (read_q == 16'hFFFF) ? read_q : read_q + 16'd1;
	assign body_inc = (body_q == 8'hFF) ? body_q : body_q + 8'd1;
	assign raw = signed'({yhi_q, ylo_q});
	assign yaw = 24'(raw) * 24'(YAW_SCALE);

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		sum_d = sum_q;
		type_d = type_q;
		ylo_d = ylo_q;
		yhi_d = yhi_q;
		read_d = read_q;
		body_d = body_q;
		res = '0;
		if (item.req_type == REQ_START) begin
			phase_d = PH_HUNT;
			pos_d = '0;
			sum_d = '0;
			body_d = '0;
			read_d = '0;
			if (read_to == 16'd0) begin
				res.valid = 1'b1;
				res.status = ST_TIMEOUT;
			end
		end else if (phase_q != PH_IDLE) begin
			unique case (item.req_type)
				REQ_TICK: begin
					read_d = read_inc;
					if (phase_q == PH_HUNT) begin
						if (read_inc >= read_to) begin
							res.valid = 1'b1;
							res.status = ST_TIMEOUT;
						end
					end else begin
						body_d = body_inc;
						if (body_inc >= body_to) begin
							res.valid = 1'b1;
							res.status = ST_TIMEOUT;
						end
					end
				end
				REQ_BYTE: begin
					if (item.rx_error) begin
						res.valid = 1'b1;
						res.status = ST_RXERR;
					end else if (phase_q == PH_HUNT) begin
						if (item.rx_byte == HDR_BYTE) begin
							phase_d = PH_BODY;
							pos_d = PosW'(1);
							sum_d = HDR_BYTE;
							body_d = '0;
						end
					end else begin
						if (pos_q == TypePos) type_d = item.rx_byte;
						if (pos_q == YawLoPos) ylo_d = item.rx_byte;
						if (pos_q == YawHiPos) yhi_d = item.rx_byte;
						if (pos_q < LastPos) begin
							sum_d = sum_q + item.rx_byte;
							pos_d = pos_q + PosW'(1);
						end else if (type_q == YAW_TYPE && sum_q == item.rx_byte) begin
							res.valid = 1'b1;
							res.status = ST_OK;
							res.yaw_q15 = yaw;
						end else begin
							phase_d = PH_HUNT;
							pos_d = '0;
							sum_d = '0;
							body_d = '0;
							if (read_q >= read_to) begin
								res.valid = 1'b1;
								res.status = ST_TIMEOUT;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (res.valid) phase_d = PH_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q <= '0;
			sum_q <= '0;
			type_q <= '0;
			ylo_q <= '0;
			yhi_q <= '0;
			read_q <= '0;
			body_q <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			sum_q <= sum_d;
			type_q <= type_d;
			ylo_q <= ylo_d;
			yhi_q <= yhi_d;
			read_q <= read_d;
			body_q <= body_d;
		end
	end

`ifndef ASSERT_OFF
	a_result_idles: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.valid |=> phase_q == PH_IDLE)
		else $error("Parser did not go idle after a result.");
	a_hunt_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HUNT |-> pos_q == '0 && sum_q == '0)
		else $error("Hunt phase with a non-zero position or sum.");
	a_body_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> pos_q != '0)
		else $error("Body phase at position zero.");
	a_err_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status != ST_OK |-> res.yaw_q15 == '0)
		else $error("Failed read carries a non-zero yaw.");
`endif

endmodule

>>> hw/rtl/imu_yaw_frame_receiver.sv
// ----------------------------------------------------------------------------
// imu_yaw_frame_receiver
// Yaw read from a serial inertial sensor: hunts for a yaw frame, checks its
// sum and reports the yaw in units of 2^-15 degree, with millisecond deadlines.
//
// Channel  Signals                          Contents
// s_axis   s_tvalid s_tready s_tdata s_tuser  request, received byte, error
// m_axis   m_tvalid m_tready m_tdata m_tuser  status, yaw
// cfg      cfg_we cfg_index cfg_data          deadline registers
//
// One item is accepted per cycle while the parser is not stalled by a result
// waiting in the output register; an accepted item is held in the input
// register until the parser advances, and its result, if any, is then
// registered in the output register, which parts the two sides, so one item
// is still taken while a result waits. Reset is asynchronous and clears
// all control state and the deadline registers to 100 ms and 20 ms.
// ----------------------------------------------------------------------------
module imu_yaw_frame_receiver
	import iyfr_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [15:0] s_tdata, // [7:0] rx_byte, [8] rx_error, rest zero
	input  logic [1:0] s_tuser,  // [1:0] req_type
	output logic m_tvalid,
	input  logic m_tready,
	output logic [23:0] m_tdata, // [23:0] yaw_q15
	output logic [1:0] m_tuser,  // [1:0] status
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] read_to_q;
	logic [7:0] body_to_q;
	logic s1_valid_q;
	item_t item_s1;
	logic advance;
	result_t res;
	logic out_valid_q;
	logic [1:0] status_q;
	logic [23:0] yaw_q;

	assign advance = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_to_q <= READ_TO_RST;
			body_to_q <= BODY_TO_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_READ_TO: read_to_q <= cfg_data;
				REG_BODY_TO: body_to_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.req_type <= s_tuser;
			item_s1.rx_byte <= s_tdata[7:0];
			item_s1.rx_error <= s_tdata[8];
		end
	end

	iyfr_parser #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.en(advance),
		.item(item_s1),
		.read_to(read_to_q),
		.body_to(body_to_q),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready) out_valid_q <= 1'b0;
			if (advance && res.valid) out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			status_q <= res.status;
			yaw_q <= res.yaw_q15;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = yaw_q;
	assign m_tuser = status_q;

endmodule
